// ----- hdl/ttg_pkg.sv -----
// Shared constants for the triangle tangent pipeline.
// No dependencies; imported by ttg_unitize and triangle_tangent_generator.
`default_nettype none

package ttg_pkg;

  // Unit vector components are Q2.30; normalized magnitudes sit in [2^30, 2^31).
  localparam int FRAC_BITS  = 30;
  localparam int UNIT_BITS  = 31;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = UNIT_BITS;

  // Stages inside one normalizer: abs, leading one, shift, square, sum,
  // square root, divider setup, divider, sign.
  localparam int UNIT_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [63:0] HALF_Q30 = 64'd1 << (FRAC_BITS - 1);
  localparam logic [32:0] HALF_Q16 = 33'd1 << 15;

endpackage

`default_nettype wire

// ----- hdl/triangle_tangent_generator.sv -----
// Top level of the per-triangle tangent pipeline.
// Uses ttg_pkg and three ttg_unitize normalizers.
`default_nettype none

// The pipe runs through two chained normalizers (70 stages each, one root
// or quotient bit per stage) with its own stages before, between and after.
// Throughput: one triangle per cycle; the whole pipe holds on out_ready low
// only while the output register is full.
// Reset (rst, synchronous): clears all valid bits; data registers are not reset.
module triangle_tangent_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] v0_x,
  input  logic signed [31:0] v0_y,
  input  logic signed [31:0] v0_z,
  input  logic signed [31:0] v1_x,
  input  logic signed [31:0] v1_y,
  input  logic signed [31:0] v1_z,
  input  logic signed [31:0] v2_x,
  input  logic signed [31:0] v2_y,
  input  logic signed [31:0] v2_z,
  input  logic signed [31:0] u_first,
  input  logic signed [31:0] u_second,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] tangent_x,
  output logic signed [15:0] tangent_y,
  output logic signed [15:0] tangent_z,
  output logic               degenerate
);
  import ttg_pkg::*;

  localparam int PIPE_LAT = 5 + UNIT_LAT + 7 + UNIT_LAT + 2;

  // Advance every stage together; hold while the result register is full.
  logic                en;
  logic [PIPE_LAT-1:0] vpipe;

  assign en        = !vpipe[PIPE_LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vpipe[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[PIPE_LAT-2:0], in_valid};
    end
  end

  logic signed [31:0] p0 [3];
  logic signed [31:0] p1 [3];
  logic signed [31:0] p2 [3];
  assign p0[0] = v0_x; assign p0[1] = v0_y; assign p0[2] = v0_z;
  assign p1[0] = v1_x; assign p1[1] = v1_y; assign p1[2] = v1_z;
  assign p2[0] = v2_x; assign p2[1] = v2_y; assign p2[2] = v2_z;

  // T1: exact edges, coincident-vertex check, sign of the u difference
  logic signed [32:0] t1_e1 [3];
  logic signed [32:0] t1_e2 [3];
  logic               t1_same;
  logic               t1_dneg;
  logic signed [32:0] du;

  assign du = 33'(u_second) - 33'(u_first);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t1_e1[i] <= 33'(p1[i]) - 33'(p0[i]);
        t1_e2[i] <= 33'(p2[i]) - 33'(p0[i]);
      end
      t1_same <= (v1_x == v0_x) && (v1_y == v0_y) && (v1_z == v0_z);
      t1_dneg <= du[32];
    end
  end

  // T2: edge magnitudes for the prescale; pick and orient the tangent edge
  logic [32:0]        t2_am [3];
  logic [32:0]        t2_bm [3];
  logic [2:0]         t2_an;
  logic [2:0]         t2_bn;
  logic signed [33:0] t2_dp [3];
  logic signed [33:0] dsel  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsel[i] = t1_same ? 34'(t1_e2[i]) : 34'(t1_e1[i]);
      if (t1_dneg) dsel[i] = -dsel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t2_an[i] <= t1_e1[i][32];
        t2_bn[i] <= t1_e2[i][32];
        t2_am[i] <= t1_e1[i][32] ? 33'(-t1_e1[i]) : 33'(t1_e1[i]);
        t2_bm[i] <= t1_e2[i][32] ? 33'(-t1_e2[i]) : 33'(t1_e2[i]);
      end
      t2_dp <= dsel;
    end
  end

  // T3: shift both edges right together until every magnitude is below 2^31
  logic [32:0]        mor;
  logic [1:0]         psh;
  logic [30:0]        am_s [3];
  logic [30:0]        bm_s [3];
  logic signed [31:0] t3_a [3];
  logic signed [31:0] t3_b [3];
  logic signed [33:0] t3_dp [3];

  always_comb begin
    mor = t2_am[0] | t2_am[1] | t2_am[2] | t2_bm[0] | t2_bm[1] | t2_bm[2];
    psh = mor[32] ? 2'd2 : (mor[31] ? 2'd1 : 2'd0);
    for (int i = 0; i < 3; i++) begin
      am_s[i] = 31'(t2_am[i] >> psh);
      bm_s[i] = 31'(t2_bm[i] >> psh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t3_a[i] <= t2_an[i] ? -$signed({1'b0, am_s[i]}) : $signed({1'b0, am_s[i]});
        t3_b[i] <= t2_bn[i] ? -$signed({1'b0, bm_s[i]}) : $signed({1'b0, bm_s[i]});
      end
      t3_dp <= t2_dp;
    end
  end

  // T4: cross-product partial products
  logic signed [63:0] t4_p [6];
  logic signed [33:0] t4_dp [3];

  always_ff @(posedge clk) begin
    if (en) begin
      t4_p[0] <= t3_a[1] * t3_b[2];
      t4_p[1] <= t3_a[2] * t3_b[1];
      t4_p[2] <= t3_a[2] * t3_b[0];
      t4_p[3] <= t3_a[0] * t3_b[2];
      t4_p[4] <= t3_a[0] * t3_b[1];
      t4_p[5] <= t3_a[1] * t3_b[0];
      t4_dp   <= t3_dp;
    end
  end

  // T5: face normal
  logic signed [63:0] t5_n [3];
  logic signed [33:0] t5_dp [3];

  always_ff @(posedge clk) begin
    if (en) begin
      t5_n[0] <= t4_p[0] - t4_p[1];
      t5_n[1] <= t4_p[2] - t4_p[3];
      t5_n[2] <= t4_p[4] - t4_p[5];
      t5_dp   <= t4_dp;
    end
  end

  // Normalize the normal and the edge side by side. A zero normal comes out
  // as zeros, which makes the projection below subtract nothing.
  logic signed [31:0] nu [3];
  logic signed [31:0] tu [3];

  ttg_unitize #(.W(64)) u_norm (
    .clk   (clk),
    .en    (en),
    .in_x  (t5_n[0]),
    .in_y  (t5_n[1]),
    .in_z  (t5_n[2]),
    .out_x (nu[0]),
    .out_y (nu[1]),
    .out_z (nu[2]),
    .nz    ()
  );

  ttg_unitize #(.W(34)) u_edge (
    .clk   (clk),
    .en    (en),
    .in_x  (t5_dp[0]),
    .in_y  (t5_dp[1]),
    .in_z  (t5_dp[2]),
    .out_x (tu[0]),
    .out_y (tu[1]),
    .out_z (tu[2]),
    .nz    ()
  );

  // P1: dot product terms
  logic signed [63:0] pr1 [3];
  logic signed [31:0] p1_nu [3];
  logic signed [31:0] p1_tu [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) pr1[i] <= nu[i] * tu[i];
      p1_nu <= nu;
      p1_tu <= tu;
    end
  end

  // P2: dot product sum, Q4.60
  logic signed [63:0] p2_d;
  logic signed [31:0] p2_nu [3];
  logic signed [31:0] p2_tu [3];

  always_ff @(posedge clk) begin
    if (en) begin
      p2_d  <= pr1[0] + pr1[1] + pr1[2];
      p2_nu <= p1_nu;
      p2_tu <= p1_tu;
    end
  end

  // P3: magnitude rounded to Q2.30 in one add (negate folded into the carry)
  logic [63:0]        d_rnd;
  logic [33:0]        p3_dm;
  logic               p3_dn;
  logic signed [31:0] p3_nu [3];
  logic signed [31:0] p3_tu [3];

  assign d_rnd = p2_d[63] ? (~p2_d + HALF_Q30 + 64'd1) : (p2_d + HALF_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_dm <= d_rnd[63:FRAC_BITS];
      p3_dn <= p2_d[63];
      p3_nu <= p2_nu;
      p3_tu <= p2_tu;
    end
  end

  // P4: signed projection length
  logic signed [34:0] p4_d;
  logic signed [31:0] p4_nu [3];
  logic signed [31:0] p4_tu [3];

  always_ff @(posedge clk) begin
    if (en) begin
      p4_d  <= p3_dn ? -$signed({1'b0, p3_dm}) : $signed({1'b0, p3_dm});
      p4_nu <= p3_nu;
      p4_tu <= p3_tu;
    end
  end

  // P5: normal component d * n
  logic signed [66:0] p5_pr [3];
  logic signed [31:0] p5_tu [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) p5_pr[i] <= p4_d * p4_nu[i];
      p5_tu <= p4_tu;
    end
  end

  // P6: round each component to Q2.30, magnitude and sign
  logic [66:0]        c_rnd [3];
  logic [36:0]        p6_m  [3];
  logic [2:0]         p6_n;
  logic signed [31:0] p6_tu [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_rnd[i] = p5_pr[i][66] ? (~p5_pr[i] + 67'(HALF_Q30) + 67'd1)
                              : (p5_pr[i] + 67'(HALF_Q30));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p6_m[i] <= c_rnd[i][66:FRAC_BITS];
        p6_n[i] <= p5_pr[i][66];
      end
      p6_tu <= p5_tu;
    end
  end

  // P7: remove the normal component
  logic signed [37:0] p7_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p7_r[i] <= p6_n[i] ? 38'(p6_tu[i]) + $signed({1'b0, p6_m[i]})
                           : 38'(p6_tu[i]) - $signed({1'b0, p6_m[i]});
      end
    end
  end

  // Final normalization; a zero remainder marks the triangle degenerate.
  logic signed [31:0] ru [3];
  logic               r_nz;

  ttg_unitize #(.W(38)) u_tan (
    .clk   (clk),
    .en    (en),
    .in_x  (p7_r[0]),
    .in_y  (p7_r[1]),
    .in_z  (p7_r[2]),
    .out_x (ru[0]),
    .out_y (ru[1]),
    .out_z (ru[2]),
    .nz    (r_nz)
  );

  // O1: round Q2.30 to Q2.14, half away from zero
  logic [32:0] q_rnd [3];
  logic [16:0] o1_m  [3];
  logic [2:0]  o1_n;
  logic        o1_nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_rnd[i] = ru[i][31] ? ({1'b0, ~ru[i]} + HALF_Q16 + 33'd1)
                           : ({1'b0, ru[i]} + HALF_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o1_m[i] <= q_rnd[i][32:16];
        o1_n[i] <= ru[i][31];
      end
      o1_nz <= r_nz;
    end
  end

  // O2: saturate, zero a degenerate result, hold in the output register
  logic signed [15:0] q14 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!o1_nz) begin
        q14[i] = '0;
      end else if (o1_n[i]) begin
        q14[i] = (o1_m[i] > 17'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, o1_m[i]}));
      end else begin
        q14[i] = (o1_m[i] > 17'd32767) ? 16'sh7fff : 16'(o1_m[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tangent_x  <= q14[0];
      tangent_y  <= q14[1];
      tangent_z  <= q14[2];
      degenerate <= !o1_nz;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ttg_unitize.sv -----
// Pipelined vector normalizer: three signed components to a Q2.30 unit vector.
// Uses ttg_pkg; built from a bit-per-stage square root and restoring divider.
`default_nettype none

module ttg_unitize #(
  parameter int W = 64
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] in_x,
  input  logic signed [W-1:0] in_y,
  input  logic signed [W-1:0] in_z,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                nz
);
  import ttg_pkg::*;

  localparam int PW = $clog2(W);

  logic signed [W-1:0] vin [3];
  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;

  // stage 1: magnitudes
  logic [W-1:0] s1_mag [3];
  logic [2:0]   s1_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg[i] <= vin[i][W-1];
        s1_mag[i] <= vin[i][W-1] ? W'(-vin[i]) : W'(vin[i]);
      end
    end
  end

  // stage 2: leading one of the largest magnitude (same as of the OR)
  logic [W-1:0]  or_v;
  logic [PW-1:0] pos_c;
  logic [W-1:0]  s2_mag [3];
  logic [2:0]    s2_neg;
  logic [PW-1:0] s2_pos;
  logic          s2_nz;

  always_comb begin
    or_v  = s1_mag[0] | s1_mag[1] | s1_mag[2];
    pos_c = '0;
    for (int i = 0; i < W; i++) begin
      if (or_v[i]) pos_c = PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag <= s1_mag;
      s2_neg <= s1_neg;
      s2_pos <= pos_c;
      s2_nz  <= |or_v;
    end
  end

  // stage 3: move the leading one to bit 30 (truncate on right shifts)
  logic [W+FRAC_BITS-1:0] wide [3];
  logic [UNIT_BITS-1:0]   s3_m [3];
  logic [2:0]             s3_neg;
  logic                   s3_nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = ({{FRAC_BITS{1'b0}}, s2_mag[i]} << FRAC_BITS) >> s2_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s3_m[i] <= wide[i][UNIT_BITS-1:0];
      s3_neg <= s2_neg;
      s3_nz  <= s2_nz;
    end
  end

  // stage 4: squares
  logic [2*UNIT_BITS-1:0] s4_sq [3];
  logic [UNIT_BITS-1:0]   s4_m [3];
  logic [2:0]             s4_neg;
  logic                   s4_nz;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s4_sq[i] <= s3_m[i] * s3_m[i];
      s4_m   <= s3_m;
      s4_neg <= s3_neg;
      s4_nz  <= s3_nz;
    end
  end

  // stage 5 feeds the root pipeline: index 0 holds the sum of squares
  logic [63:0]          sq_x   [0:SQRT_STEPS];
  logic [63:0]          sq_res [0:SQRT_STEPS];
  logic [UNIT_BITS-1:0] sq_m   [0:SQRT_STEPS][3];
  logic [2:0]           sq_neg [0:SQRT_STEPS];
  logic                 sq_nz  [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x[0]   <= 64'(s4_sq[0]) + 64'(s4_sq[1]) + 64'(s4_sq[2]);
      sq_res[0] <= '0;
      sq_m[0]   <= s4_m;
      sq_neg[0] <= s4_neg;
      sq_nz[0]  <= s4_nz;
      // one root bit per stage
      for (int k = 0; k < SQRT_STEPS; k++) begin
        if (sq_x[k] >= sq_res[k] + (64'd1 << (62 - 2 * k))) begin
          sq_x[k+1]   <= sq_x[k] - (sq_res[k] + (64'd1 << (62 - 2 * k)));
          sq_res[k+1] <= (sq_res[k] >> 1) + (64'd1 << (62 - 2 * k));
        end else begin
          sq_x[k+1]   <= sq_x[k];
          sq_res[k+1] <= sq_res[k] >> 1;
        end
        sq_m[k+1]   <= sq_m[k];
        sq_neg[k+1] <= sq_neg[k];
        sq_nz[k+1]  <= sq_nz[k];
      end
    end
  end

  // divider: q = (m * 2^30 + len/2) / len, one quotient bit per stage
  logic [31:0]                len;
  logic [2*UNIT_BITS-1:0]     numer [3];
  logic [32:0]                dv_rem [0:DIV_STEPS][3];
  logic [UNIT_BITS-1:0]       dv_low [0:DIV_STEPS][3];
  logic [UNIT_BITS-1:0]       dv_q   [0:DIV_STEPS][3];
  logic [31:0]                dv_len [0:DIV_STEPS];
  logic [2:0]                 dv_neg [0:DIV_STEPS];
  logic                       dv_nz  [0:DIV_STEPS];

  assign len = sq_res[SQRT_STEPS][31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numer[i] = (2*UNIT_BITS)'({sq_m[SQRT_STEPS][i], {FRAC_BITS{1'b0}}})
               + (2*UNIT_BITS)'(len[31:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= 33'(numer[i][2*UNIT_BITS-1:UNIT_BITS]);
        dv_low[0][i] <= numer[i][UNIT_BITS-1:0];
        dv_q[0][i]   <= '0;
      end
      dv_len[0] <= len;
      dv_neg[0] <= sq_neg[SQRT_STEPS];
      dv_nz[0]  <= sq_nz[SQRT_STEPS];
      for (int j = 0; j < DIV_STEPS; j++) begin
        for (int i = 0; i < 3; i++) begin
          if ({dv_rem[j][i][31:0], dv_low[j][i][UNIT_BITS-1]} >= {1'b0, dv_len[j]}) begin
            dv_rem[j+1][i] <= {dv_rem[j][i][31:0], dv_low[j][i][UNIT_BITS-1]}
                            - {1'b0, dv_len[j]};
            dv_q[j+1][i]   <= {dv_q[j][i][UNIT_BITS-2:0], 1'b1};
          end else begin
            dv_rem[j+1][i] <= {dv_rem[j][i][31:0], dv_low[j][i][UNIT_BITS-1]};
            dv_q[j+1][i]   <= {dv_q[j][i][UNIT_BITS-2:0], 1'b0};
          end
          dv_low[j+1][i] <= {dv_low[j][i][UNIT_BITS-2:0], 1'b0};
        end
        dv_len[j+1] <= dv_len[j];
        dv_neg[j+1] <= dv_neg[j];
        dv_nz[j+1]  <= dv_nz[j];
      end
    end
  end

  // final stage: restore signs, drop the zero vector
  logic signed [31:0] qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = $signed({1'b0, dv_q[DIV_STEPS][i]});
      if (!dv_nz[DIV_STEPS]) qs[i] = '0;
      else if (dv_neg[DIV_STEPS][i]) qs[i] = -$signed({1'b0, dv_q[DIV_STEPS][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= qs[0];
      out_y <= qs[1];
      out_z <= qs[2];
      nz    <= dv_nz[DIV_STEPS];
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_triangle_tangent_generator.sv -----
// Self-checking testbench for triangle_tangent_generator.
// Depends on hdl/ttg_pkg.sv and hdl/triangle_tangent_generator.sv; predicts each
// unit tangent in bit-exact fixed point and checks results in arrival order.
`timescale 1ns / 1ps

module tb_triangle_tangent_generator;

  typedef struct {
    logic signed [31:0] v [9];
    logic signed [31:0] u0;
    logic signed [31:0] u1;
  } tri_t;

  typedef struct {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic               degen;
  } tan_t;

  localparam int PIPE_DEPTH  = 154;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] v0_x = '0, v0_y = '0, v0_z = '0;
  logic signed [31:0] v1_x = '0, v1_y = '0, v1_z = '0;
  logic signed [31:0] v2_x = '0, v2_y = '0, v2_z = '0;
  logic signed [31:0] u_first = '0, u_second = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] tangent_x, tangent_y, tangent_z;
  logic degenerate;

  tan_t expected_tangents[$];
  int   error_count = 0;
  int   idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  triangle_tangent_generator u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
    .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
    .u_first(u_first), .u_second(u_second),
    .out_valid(out_valid), .out_ready(out_ready),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .degenerate(degenerate)
  );

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Round half away from zero of v / 2^30.
  function automatic logic signed [63:0] round_q30(logic signed [63:0] v);
    logic [63:0] m;
    m = (abs64(v) + 64'(1 << 29)) >> 30;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Scale to [2^30, 2^31), divide by length; returns 0 for a zero vector.
  function automatic bit make_unit(input logic signed [63:0] vin [3],
                                   output logic signed [63:0] vout [3]);
    logic [63:0] m [3];
    logic [63:0] peak, sumsq, len, q;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(vin[i]);
      if (m[i] > peak) peak = m[i];
      vout[i] = 0;
    end
    if (peak == 0) return 1'b0;
    while (peak >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      peak >>= 1;
    end
    while (peak < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      peak <<= 1;
    end
    sumsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      vout[i] = vin[i][63] ? -$signed(q) : $signed(q);
    end
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] to_q14(logic signed [63:0] v);
    logic [63:0] m;
    logic signed [63:0] q;
    m = (abs64(v) + 64'(1 << 15)) >> 16;
    q = v[63] ? -$signed(m) : $signed(m);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic tan_t tangent_of(tri_t t);
    logic signed [63:0] p [9];
    logic signed [63:0] e1 [3], e2 [3], a [3], b [3], nrm [3], edge_t [3];
    logic signed [63:0] nu [3], tu [3], rem [3], ru [3];
    logic signed [63:0] du, dotp;
    logic [63:0] peak;
    bit coincident, has_normal, ok;
    tan_t res;
    for (int i = 0; i < 9; i++) p[i] = t.v[i];
    du = 64'(t.u1) - 64'(t.u0);
    coincident = 1'b1;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[3 + i] - p[i];
      e2[i] = p[6 + i] - p[i];
      if (p[3 + i] != p[i]) coincident = 1'b0;
      a[i] = e1[i];
      b[i] = e2[i];
      if (abs64(a[i]) > peak) peak = abs64(a[i]);
      if (abs64(b[i]) > peak) peak = abs64(b[i]);
    end
    // Shift both edges together (toward zero) so the cross products fit.
    while (peak >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = a[i][63] ? -$signed(abs64(a[i]) >> 1) : $signed(abs64(a[i]) >> 1);
        b[i] = b[i][63] ? -$signed(abs64(b[i]) >> 1) : $signed(abs64(b[i]) >> 1);
      end
      peak >>= 1;
    end
    nrm[0] = a[1] * b[2] - a[2] * b[1];
    nrm[1] = a[2] * b[0] - a[0] * b[2];
    nrm[2] = a[0] * b[1] - a[1] * b[0];
    // Only the sign of du matters once the edge is normalized.
    for (int i = 0; i < 3; i++) begin
      edge_t[i] = coincident ? e2[i] : e1[i];
      if (du < 0) edge_t[i] = -edge_t[i];
    end
    has_normal = make_unit(nrm, nu);
    if (!make_unit(edge_t, tu)) begin
      ok = 1'b0;
      for (int i = 0; i < 3; i++) ru[i] = 0;
    end else begin
      if (has_normal) begin
        dotp = round_q30(nu[0] * tu[0] + nu[1] * tu[1] + nu[2] * tu[2]);
        for (int i = 0; i < 3; i++) rem[i] = tu[i] - round_q30(dotp * nu[i]);
      end else begin
        for (int i = 0; i < 3; i++) rem[i] = tu[i];
      end
      ok = make_unit(rem, ru);
    end
    res.tx = ok ? to_q14(ru[0]) : '0;
    res.ty = ok ? to_q14(ru[1]) : '0;
    res.tz = ok ? to_q14(ru[2]) : '0;
    res.degen = !ok;
    return res;
  endfunction

  // ------------------------------------------------------------ stimulus side
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Hold the transaction until accepted; keep valid high across back-to-back items.
  task automatic send_triangle(tri_t t);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    v0_x <= t.v[0]; v0_y <= t.v[1]; v0_z <= t.v[2];
    v1_x <= t.v[3]; v1_y <= t.v[4]; v1_z <= t.v[5];
    v2_x <= t.v[6]; v2_y <= t.v[7]; v2_z <= t.v[8];
    u_first <= t.u0;
    u_second <= t.u1;
    expected_tangents.push_back(tangent_of(t));
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic tri_t random_triangle();
    tri_t t;
    for (int i = 0; i < 9; i++) t.v[i] = rand_coord();
    t.u0 = rand_coord();
    t.u1 = rand_coord();
    case ($urandom_range(0, 15))
      0: for (int i = 0; i < 3; i++) t.v[3 + i] = t.v[i];                // v0 == v1
      1: for (int i = 0; i < 3; i++) t.v[6 + i] = t.v[3 + i];            // collinear
      2: t.u1 = t.u0;                                                     // zero du
      3: for (int i = 0; i < 3; i++) t.v[6 + i] = 2 * t.v[3 + i] - t.v[i];
      default: ;
    endcase
    return t;
  endfunction

  function automatic tri_t build_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                     int x2, int y2, int z2, int ua, int ub);
    tri_t t;
    t.v = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
    t.u0 = ua;
    t.u1 = ub;
    return t;
  endfunction

  task automatic test_directed();
    localparam int ONE = 32'h0001_0000;
    localparam int MAXV = 32'h7FFF_FFFF;
    localparam int MINV = 32'h8000_0000;
    send_triangle(build_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE));      // plain
    send_triangle(build_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 0));      // negative du
    send_triangle(build_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 5, 5));        // zero du
    send_triangle(build_tri(0, 0, 0, 0, 0, 0, 0, ONE, ONE, 0, ONE));      // v0 == v1
    send_triangle(build_tri(7, 7, 7, 7, 7, 7, 7, 7, 7, 0, ONE));          // all coincident
    send_triangle(build_tri(0, 0, 0, ONE, ONE, 0, 2*ONE, 2*ONE, 0, 0, 1)); // collinear
    send_triangle(build_tri(0, 0, 0, ONE, ONE, ONE, 0, 0, ONE, 0, 1));    // tilted
    send_triangle(build_tri(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MINV,
                            MINV, MAXV));                                  // extremes
    send_triangle(build_tri(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV,
                            MAXV, MINV));
    send_triangle(build_tri(MINV, 0, MAXV, MAXV, 0, MINV, 0, MAXV, 0, MAXV, MAXV));
    send_triangle(build_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, -1, 0));            // smallest steps
    send_triangle(build_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, MINV, MINV));
    send_triangle(build_tri(0, 0, 0, 3, 1, 0, 0, 0, 1, 0, ONE));
  endtask

  task automatic test_random();
    repeat (2000) send_triangle(random_triangle());
  endtask

  // Long burst with no source gaps so the pipe fills under receiver stalls.
  task automatic test_back_to_back();
    tri_t t;
    in_valid <= 1'b1;
    repeat (200) begin
      t = random_triangle();
      v0_x <= t.v[0]; v0_y <= t.v[1]; v0_z <= t.v[2];
      v1_x <= t.v[3]; v1_y <= t.v[4]; v1_z <= t.v[5];
      v2_x <= t.v[6]; v2_y <= t.v[7]; v2_z <= t.v[8];
      u_first <= t.u0;
      u_second <= t.u1;
      expected_tangents.push_back(tangent_of(t));
      do @(posedge clk); while (!in_ready);
    end
  endtask

  // ----------------------------------------------------------------- checking
  // Toggle out_ready with random stalls, with occasional fully open stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    tan_t exp_t;
    if (!rst && out_valid && out_ready) begin
      if (expected_tangents.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        exp_t = expected_tangents.pop_front();
        if (tangent_x !== exp_t.tx) begin
          $error("tangent_x expected %0d actual %0d", exp_t.tx, tangent_x);
          error_count++;
        end
        if (tangent_y !== exp_t.ty) begin
          $error("tangent_y expected %0d actual %0d", exp_t.ty, tangent_y);
          error_count++;
        end
        if (tangent_z !== exp_t.tz) begin
          $error("tangent_z expected %0d actual %0d", exp_t.tz, tangent_z);
          error_count++;
        end
        if (degenerate !== exp_t.degen) begin
          $error("degenerate expected %0d actual %0d", exp_t.degen, degenerate);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_triangle_tangent_generator: errors");
      $finish;
    end
  end

  // ----------------------------------------------------------------- sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_back_to_back();
    in_valid <= 1'b0;
    // Drain: the watchdog covers a hung pipe.
    while (expected_tangents.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_triangle_tangent_generator: clean");
    end else begin
      $display("tb_triangle_tangent_generator: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ttg_pkg.sv
hdl/ttg_unitize.sv
hdl/triangle_tangent_generator.sv
test/tb_triangle_tangent_generator.sv
